FILE: design/tdc_pkg.sv
package tdc_pkg;

	// field widths
	localparam int TEMP_WIDTH  = 12;
	localparam int TARGET_STEP = 8;
	localparam int MARGIN_W    = 11;
	localparam int DELAY_W     = 31;
	localparam int TIME_W      = 32;
	localparam int MODE_W      = 3;
	localparam int BUTTON_W    = 2;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	// deadband bounds hold target +/- margin without wrap
	localparam int BOUND_W = ((TEMP_WIDTH > MARGIN_W + 1) ? TEMP_WIDTH : MARGIN_W + 1) + 1;

	// register reset values
	localparam logic [MARGIN_W-1:0]          MARGIN_RST = MARGIN_W'(16);
	localparam logic [DELAY_W-1:0]           DELAY_RST  = DELAY_W'(180000);
	localparam logic signed [TEMP_WIDTH-1:0] TARGET_RST = TEMP_WIDTH'(400);

	// register map, word index
	localparam logic [1:0] REG_MARGIN      = 2'd0;
	localparam logic [1:0] REG_DELAY       = 2'd1;
	localparam logic [1:0] REG_INIT_TARGET = 2'd2;

	// button codes
	localparam logic [BUTTON_W-1:0] BTN_UP   = BUTTON_W'(1);
	localparam logic [BUTTON_W-1:0] BTN_DOWN = BUTTON_W'(2);

	typedef enum logic [MODE_W-1:0] {
		ST_IDLE      = 3'd0,
		ST_INIT_HOT  = 3'd1,
		ST_WAIT_HOT  = 3'd2,
		ST_COOLING   = 3'd3,
		ST_INIT_COLD = 3'd4,
		ST_WAIT_COLD = 3'd5,
		ST_HEATING   = 3'd6
	} ctrl_state_t;

	typedef struct packed {
		logic [MARGIN_W-1:0] margin;
		logic [DELAY_W-1:0]  delay;
	} cfg_t;

	typedef struct packed {
		logic                         cooler;
		logic                         heater;
		logic                         hot_warn;
		logic                         cold_warn;
		logic [MODE_W-1:0]            mode;
		logic signed [TEMP_WIDTH-1:0] target;
	} result_t;

endpackage

FILE: design/thermostat_delay_deadband_control_core.sv
// pipeline: a word accepted into the input register steps the controller and is presented from the result register
// throughput: one word per cycle while out_ready stays high; a held result stalls both stages
// the controller state updates when a word moves from the input register to the result register
// reset: asynchronous, active low; idle state, target 400, latches, delay start and
// registers back to their reset values, both pipeline stages empty
module thermostat_delay_deadband_control_core
	import tdc_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ADDR_W-1:0]            paddr,
	input  logic [DATA_W-1:0]            pwdata,
	output logic [DATA_W-1:0]            prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [TEMP_WIDTH-1:0] temperature,
	input  logic [BUTTON_W-1:0]          button,
	input  logic [TIME_W-1:0]            now_ms,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         cooler_drive,
	output logic                         heater_drive,
	output logic                         hot_warning,
	output logic                         cold_warning,
	output logic [MODE_W-1:0]            mode,
	output logic signed [TEMP_WIDTH-1:0] target_now
);

	cfg_t                         cfg;
	result_t                      res;
	result_t                      res_s2;
	logic                         valid_s1, valid_s2;
	logic signed [TEMP_WIDTH-1:0] temperature_s1;
	logic [BUTTON_W-1:0]          button_s1;
	logic [TIME_W-1:0]            now_ms_s1;
	logic                         s1_fire;

	assign pready = 1'b1;

	tdc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// stage handshake
	assign s1_fire  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || s1_fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			temperature_s1 <= temperature;
			button_s1      <= button;
			now_ms_s1      <= now_ms;
		end
	end

	tdc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (s1_fire),
		.temperature (temperature_s1),
		.button      (button_s1),
		.now_ms      (now_ms_s1),
		.cfg         (cfg),
		.res         (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_fire) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign cooler_drive = res_s2.cooler;
	assign heater_drive = res_s2.heater;
	assign hot_warning  = res_s2.hot_warn;
	assign cold_warning = res_s2.cold_warn;
	assign mode         = res_s2.mode;
	assign target_now   = res_s2.target;

endmodule

FILE: design/tdc_regs.sv
module tdc_regs
	import tdc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	logic [MARGIN_W-1:0]          margin_q;
	logic [DELAY_W-1:0]           delay_q;
	logic signed [TEMP_WIDTH-1:0] init_target_q;
	logic                         wr_en;
	logic [1:0]                   reg_idx;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q      <= MARGIN_RST;
			delay_q       <= DELAY_RST;
			init_target_q <= TARGET_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MARGIN:      margin_q      <= pwdata[MARGIN_W-1:0];
				REG_DELAY:       delay_q       <= pwdata[DELAY_W-1:0];
				REG_INIT_TARGET: init_target_q <= pwdata[TEMP_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			REG_MARGIN:      prdata = DATA_W'(margin_q);
			REG_DELAY:       prdata = DATA_W'(delay_q);
			REG_INIT_TARGET: prdata = DATA_W'(init_target_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.margin = margin_q;
	assign cfg.delay  = delay_q;

endmodule

FILE: design/tdc_core.sv
module tdc_core
	import tdc_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step_en,
	input  logic signed [TEMP_WIDTH-1:0] temperature,
	input  logic [BUTTON_W-1:0]          button,
	input  logic [TIME_W-1:0]            now_ms,
	input  cfg_t                         cfg,
	output result_t                      res
);

	localparam logic signed [TEMP_WIDTH:0] TMAX_EXT = (TEMP_WIDTH+1)'((1 << (TEMP_WIDTH-1)) - 1);
	localparam logic signed [TEMP_WIDTH:0] TMIN_EXT = -(TEMP_WIDTH+1)'(1 << (TEMP_WIDTH-1));
	localparam logic signed [TEMP_WIDTH:0] STEP_EXT = (TEMP_WIDTH+1)'(TARGET_STEP);

	ctrl_state_t                  state_q, state_d;
	logic signed [TEMP_WIDTH-1:0] target_q, target_d;
	logic [TIME_W-1:0]            start_q, start_d;
	logic                         cooler_q, cooler_d;
	logic                         heater_q, heater_d;
	logic                         hot_warn_q, hot_warn_d;
	logic                         cold_warn_q, cold_warn_d;

	logic signed [TEMP_WIDTH:0]   tgt_ext, tgt_up, tgt_dn;
	logic signed [BOUND_W-1:0]    tgt_b, margin_b, temp_b, hi, lo;
	logic [TIME_W-1:0]            elapsed;
	logic                         delay_done;

	// target step with saturation
	always_comb begin
		tgt_ext = {target_q[TEMP_WIDTH-1], target_q};
		tgt_up  = tgt_ext + STEP_EXT;
		tgt_dn  = tgt_ext - STEP_EXT;
		case (button)
			BTN_UP:   target_d = (tgt_up > TMAX_EXT) ? TMAX_EXT[TEMP_WIDTH-1:0]
			                                         : tgt_up[TEMP_WIDTH-1:0];
			BTN_DOWN: target_d = (tgt_dn < TMIN_EXT) ? TMIN_EXT[TEMP_WIDTH-1:0]
			                                         : tgt_dn[TEMP_WIDTH-1:0];
			default:  target_d = target_q;
		endcase
	end

	// deadband bounds around the updated target
	always_comb begin
		tgt_b    = $signed({{(BOUND_W-TEMP_WIDTH){target_d[TEMP_WIDTH-1]}}, target_d});
		margin_b = $signed({{(BOUND_W-MARGIN_W){1'b0}}, cfg.margin});
		temp_b   = $signed({{(BOUND_W-TEMP_WIDTH){temperature[TEMP_WIDTH-1]}}, temperature});
		hi       = tgt_b + margin_b;
		lo       = tgt_b - margin_b;
	end

	// delay expired, a negative elapsed time counts as expired
	assign elapsed    = now_ms - start_q;
	assign delay_done = elapsed[TIME_W-1] || (elapsed[TIME_W-2:0] > cfg.delay);

	// state actions
	always_comb begin
		start_d     = start_q;
		cooler_d    = cooler_q;
		heater_d    = heater_q;
		hot_warn_d  = hot_warn_q;
		cold_warn_d = cold_warn_q;
		case (state_q)
			ST_INIT_HOT: begin
				start_d    = now_ms;
				hot_warn_d = 1'b1;
			end
			ST_WAIT_HOT, ST_WAIT_COLD: ;
			ST_COOLING: begin
				hot_warn_d = 1'b0;
				cooler_d   = 1'b1;
			end
			ST_INIT_COLD: begin
				start_d     = now_ms;
				cold_warn_d = 1'b1;
			end
			ST_HEATING: begin
				cold_warn_d = 1'b0;
				heater_d    = 1'b1;
			end
			default: begin
				start_d     = '0;
				cooler_d    = 1'b0;
				heater_d    = 1'b0;
				hot_warn_d  = 1'b0;
				cold_warn_d = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT_HOT: state_d = ST_WAIT_HOT;
			ST_WAIT_HOT: begin
				if (temp_b <= hi) state_d = ST_IDLE;
				else if (delay_done) state_d = ST_COOLING;
			end
			ST_COOLING: begin
				if (temp_b <= lo) state_d = ST_IDLE;
			end
			ST_INIT_COLD: state_d = ST_WAIT_COLD;
			ST_WAIT_COLD: begin
				if (temp_b >= lo) state_d = ST_IDLE;
				else if (delay_done) state_d = ST_HEATING;
			end
			ST_HEATING: begin
				if (temp_b >= hi) state_d = ST_IDLE;
			end
			default: begin
				if (temp_b > hi) state_d = ST_INIT_HOT;
				else if (temp_b < lo) state_d = ST_INIT_COLD;
				else state_d = ST_IDLE;
			end
		endcase
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			target_q    <= TARGET_RST;
			start_q     <= '0;
			cooler_q    <= 1'b0;
			heater_q    <= 1'b0;
			hot_warn_q  <= 1'b0;
			cold_warn_q <= 1'b0;
		end else if (step_en) begin
			state_q     <= state_d;
			target_q    <= target_d;
			start_q     <= start_d;
			cooler_q    <= cooler_d;
			heater_q    <= heater_d;
			hot_warn_q  <= hot_warn_d;
			cold_warn_q <= cold_warn_d;
		end
	end

	// result word for this tick
	assign res.cooler    = cooler_d;
	assign res.heater    = heater_d;
	assign res.hot_warn  = hot_warn_d;
	assign res.cold_warn = cold_warn_d;
	assign res.mode      = state_d;
	assign res.target    = target_d;

	// cooler and heater never drive together
	a_drive_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cooler_q && heater_q))
		else $error("cooler and heater both on");

	// waiting out the hot delay always shows the hot warning
	a_wait_hot_warn: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT_HOT) |-> hot_warn_q)
		else $error("wait hot without hot warning");

	// cooling path carries nothing from the cold side
	a_cool_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COOLING) |-> (!heater_q && !cold_warn_q))
		else $error("cold side latch set while cooling");

endmodule
